/* design/tlg_pkg.sv */
package tlg_pkg;

    // Result queue sizing: one item pushes at most two lines
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int MAX_PUSH   = 2;

    // Write request from the grouping core to the result queue.
    // slot1 is only set together with slot0.
    typedef struct packed {
        logic slot0;
        logic slot1;
    } tlg_push_t;

endpackage

/* design/tlg_in_reg.sv */
module tlg_in_reg
    import tlg_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [COORD_BITS-1:0] box_left,
    input  logic [COORD_BITS-1:0] box_top,
    input  logic [COORD_BITS-1:0] box_right,
    input  logic [COORD_BITS-1:0] box_bottom,
    input  logic                  last_box,
    input  logic                  take,
    output logic                  item_valid,
    output logic [COORD_BITS-1:0] item_left,
    output logic [COORD_BITS-1:0] item_top,
    output logic [COORD_BITS-1:0] item_right,
    output logic [COORD_BITS-1:0] item_bottom,
    output logic                  item_last
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [COORD_BITS-1:0] left_reg;
    logic [COORD_BITS-1:0] top_reg;
    logic [COORD_BITS-1:0] right_reg;
    logic [COORD_BITS-1:0] bottom_reg;
    logic                  last_reg;
    logic                  load;

    // Accept a new box when the stage is empty or drains this cycle
    assign s_tready = !valid_reg || take;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the box payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            left_reg   <= box_left;
            top_reg    <= box_top;
            right_reg  <= box_right;
            bottom_reg <= box_bottom;
            last_reg   <= last_box;
        end
    end

    assign item_valid  = valid_reg;
    assign item_left   = left_reg;
    assign item_top    = top_reg;
    assign item_right  = right_reg;
    assign item_bottom = bottom_reg;
    assign item_last   = last_reg;

endmodule

/* design/tlg_core.sv */
module tlg_core
    import tlg_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int INDEX_BITS = 16,
    localparam int RES_W     = 2 * INDEX_BITS + 4 * COORD_BITS + 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic [COORD_BITS-1:0] item_left,
    input  logic [COORD_BITS-1:0] item_top,
    input  logic [COORD_BITS-1:0] item_right,
    input  logic [COORD_BITS-1:0] item_bottom,
    input  logic                  item_last,
    input  logic                  space_ok,
    output logic                  take,
    output tlg_push_t             push,
    // {index_overflow, last_line, bottom, right, top, left, end_char, first_char}
    output logic [RES_W-1:0]      res0,
    output logic [RES_W-1:0]      res1
);

    localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

    logic [COORD_BITS-1:0] left_reg,   left_next;
    logic [COORD_BITS-1:0] top_reg,    top_next;
    logic [COORD_BITS-1:0] right_reg,  right_next;
    logic [COORD_BITS-1:0] bottom_reg, bottom_next;
    logic [INDEX_BITS-1:0] start_reg,  start_next;
    logic [INDEX_BITS-1:0] count_reg,  count_next;
    logic                  open_reg,   open_next;
    logic                  ovf_reg,    ovf_next;

    logic [INDEX_BITS-1:0] idx_next;
    logic [INDEX_BITS-1:0] line_start;
    logic                  at_max;
    logic                  ovf;
    logic                  joins;
    logic                  closes;
    logic                  rect_null;
    logic                  box_null;
    logic [COORD_BITS-1:0] rl_lo, rl_hi, rt_lo, rt_hi;
    logic [COORD_BITS-1:0] bl_lo, bl_hi, bt_lo, bt_hi;
    logic [COORD_BITS-1:0] u_left, u_right, u_top, u_bottom;
    logic [COORD_BITS-1:0] m_left, m_top, m_right, m_bottom;
    logic [RES_W-1:0]      close_line;
    logic [RES_W-1:0]      flush_line;

    assign take = item_valid && space_ok;

    // Saturating character index
    assign at_max   = (count_reg == INDEX_MAX);
    assign idx_next = at_max ? INDEX_MAX : count_reg + 1'b1;
    assign ovf      = ovf_reg || at_max;

    // Vertical span test against the open line
    assign joins  = open_reg && (item_top <= bottom_reg) && (item_bottom >= top_reg);
    assign closes = open_reg && !joins;

    // Union with each edge pair sorted first
    assign rect_null = (left_reg == right_reg) && (top_reg == bottom_reg);
    assign box_null  = (item_left == item_right) && (item_top == item_bottom);

    assign rl_lo = (left_reg < right_reg) ? left_reg : right_reg;
    assign rl_hi = (left_reg < right_reg) ? right_reg : left_reg;
    assign rt_lo = (top_reg < bottom_reg) ? top_reg : bottom_reg;
    assign rt_hi = (top_reg < bottom_reg) ? bottom_reg : top_reg;
    assign bl_lo = (item_left < item_right) ? item_left : item_right;
    assign bl_hi = (item_left < item_right) ? item_right : item_left;
    assign bt_lo = (item_top < item_bottom) ? item_top : item_bottom;
    assign bt_hi = (item_top < item_bottom) ? item_bottom : item_top;

    assign u_left   = (rl_lo < bl_lo) ? rl_lo : bl_lo;
    assign u_right  = (rl_hi > bl_hi) ? rl_hi : bl_hi;
    assign u_top    = (rt_lo < bt_lo) ? rt_lo : bt_lo;
    assign u_bottom = (rt_hi > bt_hi) ? rt_hi : bt_hi;

    // Rectangle of the line after this box
    always_comb
    begin
        m_left     = item_left;
        m_top      = item_top;
        m_right    = item_right;
        m_bottom   = item_bottom;
        line_start = count_reg;
        if (joins)
        begin
            line_start = start_reg;
            priority if (rect_null)
            begin
                m_left   = item_left;
                m_top    = item_top;
                m_right  = item_right;
                m_bottom = item_bottom;
            end
            else if (box_null)
            begin
                m_left   = left_reg;
                m_top    = top_reg;
                m_right  = right_reg;
                m_bottom = bottom_reg;
            end
            else
            begin
                m_left   = u_left;
                m_top    = u_top;
                m_right  = u_right;
                m_bottom = u_bottom;
            end
        end
    end

    // Lines emitted by this box
    assign close_line = {ovf, 1'b0, bottom_reg, right_reg, top_reg, left_reg,
                         count_reg, start_reg};
    assign flush_line = {ovf, 1'b1, m_bottom, m_right, m_top, m_left,
                         idx_next, line_start};

    always_comb
    begin
        push.slot0 = take && (closes || item_last);
        push.slot1 = take && closes && item_last;
        res0       = closes ? close_line : flush_line;
        res1       = flush_line;
    end

    // Next state: a last box returns everything to the page start
    always_comb
    begin
        left_next   = m_left;
        top_next    = m_top;
        right_next  = m_right;
        bottom_next = m_bottom;
        start_next  = line_start;
        count_next  = idx_next;
        open_next   = 1'b1;
        ovf_next    = ovf;
        if (item_last)
        begin
            left_next   = '0;
            top_next    = '0;
            right_next  = '0;
            bottom_next = '0;
            start_next  = '0;
            count_next  = '0;
            open_next   = 1'b0;
            ovf_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
            start_reg  <= '0;
            count_reg  <= '0;
            open_reg   <= 1'b0;
            ovf_reg    <= 1'b0;
        end
        else if (take)
        begin
            left_reg   <= left_next;
            top_reg    <= top_next;
            right_reg  <= right_next;
            bottom_reg <= bottom_next;
            start_reg  <= start_next;
            count_reg  <= count_next;
            open_reg   <= open_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

/* design/tlg_out_fifo.sv */
module tlg_out_fifo
    import tlg_pkg::*;
#(
    parameter int WIDTH = 98
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  tlg_push_t        push,
    input  logic [WIDTH-1:0] res0,
    input  logic [WIDTH-1:0] res1,
    output logic             space_ok,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PTR_W-1:0] wr_second;
    logic             pop;

    assign space_ok  = cnt_reg <= CNT_W'(FIFO_DEPTH - MAX_PUSH);
    assign out_valid = cnt_reg != '0;
    assign out_data  = entry_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    assign wr_second = wr_reg + 1'b1;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_next  = wr_reg + PTR_W'(push.slot0) + PTR_W'(push.slot1);
        rd_next  = rd_reg + PTR_W'(pop);
        cnt_next = cnt_reg + CNT_W'(push.slot0) + CNT_W'(push.slot1) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store up to two lines per cycle
    always_ff @(posedge clk)
    begin
        if (push.slot0)
        begin
            entry_reg[wr_reg] <= res0;
        end
        if (push.slot1)
        begin
            entry_reg[wr_second] <= res1;
        end
    end

endmodule

/* design/text_line_grouping_unit.sv */
// Channel  Direction  tdata                                    tlast      tuser
// s_axis   in         box_left, box_top, box_right, box_bottom last_box   -
// m_axis   out        first_char, end_char, rect_left,         last_line  index_overflow
//                     rect_top, rect_right, rect_bottom
//
// One box per cycle while the queue has room: a box is held in the input register,
// then the span test and union against the open line rectangle update the line
// state and push zero, one or two lines into a four-entry result queue.
// A box that emits two lines writes both into the queue in the same cycle; the input
// side keeps accepting while the queue has two free entries.
// rst_n clears the open line, the character counter and the queue.
// Output stalls back up into the input once the queue fills.
module text_line_grouping_unit
    import tlg_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int INDEX_BITS = 16,
    localparam int S_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int M_DATA_W  = ((2 * INDEX_BITS + 4 * COORD_BITS + 7) / 8) * 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // box_left, box_top, box_right, box_bottom
    input  logic                s_tlast,  // last_box
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // first_char, end_char, rect_left, rect_top,
                                          // rect_right, rect_bottom
    output logic                m_tlast,  // last_line
    output logic                m_tuser   // index_overflow
);

    localparam int RES_DATA_W = 2 * INDEX_BITS + 4 * COORD_BITS;
    localparam int RES_W      = RES_DATA_W + 2;

    logic                  item_valid;
    logic [COORD_BITS-1:0] item_left;
    logic [COORD_BITS-1:0] item_top;
    logic [COORD_BITS-1:0] item_right;
    logic [COORD_BITS-1:0] item_bottom;
    logic                  item_last;
    logic                  take;
    logic                  space_ok;
    tlg_push_t             push;
    logic [RES_W-1:0]      res0;
    logic [RES_W-1:0]      res1;
    logic [RES_W-1:0]      out_data;

    tlg_in_reg #(
        .COORD_BITS (COORD_BITS)
    ) u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .box_left    (s_tdata[COORD_BITS-1:0]),
        .box_top     (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .box_right   (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .box_bottom  (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .last_box    (s_tlast),
        .take        (take),
        .item_valid  (item_valid),
        .item_left   (item_left),
        .item_top    (item_top),
        .item_right  (item_right),
        .item_bottom (item_bottom),
        .item_last   (item_last)
    );

    tlg_core #(
        .COORD_BITS (COORD_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_left   (item_left),
        .item_top    (item_top),
        .item_right  (item_right),
        .item_bottom (item_bottom),
        .item_last   (item_last),
        .space_ok    (space_ok),
        .take        (take),
        .push        (push),
        .res0        (res0),
        .res1        (res1)
    );

    tlg_out_fifo #(
        .WIDTH (RES_W)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .res0      (res0),
        .res1      (res1),
        .space_ok  (space_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    // Unpack the queued line onto the master side
    assign m_tdata = M_DATA_W'(out_data[RES_DATA_W-1:0]);
    assign m_tlast = out_data[RES_DATA_W];
    assign m_tuser = out_data[RES_DATA_W+1];

endmodule

/* design/tlg_checker.sv */
module tlg_checker #(
    parameter int COORD_BITS = 16,
    parameter int INDEX_BITS = 16,
    localparam int M_DATA_W  = ((2 * INDEX_BITS + 4 * COORD_BITS + 7) / 8) * 8
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tlast,
    input logic                m_tuser
);

    logic [INDEX_BITS-1:0] first_char;
    logic [INDEX_BITS-1:0] end_char;

    assign first_char = m_tdata[INDEX_BITS-1:0];
    assign end_char   = m_tdata[2*INDEX_BITS-1:INDEX_BITS];

    // Hold a stalled transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
        else $error("output payload changed while stalled");

    // A line never ends before it starts
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> end_char >= first_char)
        else $error("end_char below first_char");

    // A saturated counter pins the end index at its maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> end_char == '1)
        else $error("overflow flagged without saturated end_char");

endmodule

bind text_line_grouping_unit tlg_checker #(
    .COORD_BITS (COORD_BITS),
    .INDEX_BITS (INDEX_BITS)
) u_tlg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

/* dv/tb_top.sv */
`timescale 1ns / 100ps

// One closed text line as it leaves the block
typedef struct packed {
    logic [15:0] first_char;
    logic [15:0] end_char;
    logic [15:0] rect_left;
    logic [15:0] rect_top;
    logic [15:0] rect_right;
    logic [15:0] rect_bottom;
    logic        last_line;
    logic        index_overflow;
} text_line_t;

// Track the open line of the page and the lines still owed by the block
class text_line_tracker;
    logic [15:0] cur_left, cur_top, cur_right, cur_bottom;
    logic [15:0] cur_first, next_index;
    bit          line_open, saturated;
    text_line_t  awaited_lines[$];
    int          mismatch_count;

    function new();
        clear_page();
        mismatch_count = 0;
    endfunction

    // Return to the start of a page
    function void clear_page();
        cur_left   = '0;
        cur_top    = '0;
        cur_right  = '0;
        cur_bottom = '0;
        cur_first  = '0;
        next_index = '0;
        line_open  = 1'b0;
        saturated  = 1'b0;
    endfunction

    // Queue the open line as an expected result
    function void close_line(logic [15:0] end_idx, bit last_flag, bit ovf);
        text_line_t ln;
        ln.first_char     = cur_first;
        ln.end_char       = end_idx;
        ln.rect_left      = cur_left;
        ln.rect_top       = cur_top;
        ln.rect_right     = cur_right;
        ln.rect_bottom    = cur_bottom;
        ln.last_line      = last_flag;
        ln.index_overflow = ovf;
        awaited_lines.push_back(ln);
    endfunction

    // Apply one accepted box transaction to the line state
    function void take_box(logic [15:0] l, logic [15:0] t, logic [15:0] r,
                           logic [15:0] b, bit last_flag);
        logic [15:0] idx, nxt;
        logic [15:0] bx_lo, bx_hi, by_lo, by_hi, cx_lo, cx_hi, cy_lo, cy_hi;
        bit          ovf, box_null, rect_null;
        idx = next_index;
        nxt = (idx != 16'hffff) ? idx + 16'd1 : idx;
        ovf = saturated || (idx == 16'hffff);
        if (line_open && t <= cur_bottom && b >= cur_top)
        begin
            // Join: grow the rectangle, with null boxes and null rectangles special
            box_null  = (l == r) && (t == b);
            rect_null = (cur_left == cur_right) && (cur_top == cur_bottom);
            if (rect_null)
            begin
                cur_left   = l;
                cur_top    = t;
                cur_right  = r;
                cur_bottom = b;
            end
            else if (!box_null)
            begin
                bx_lo = (l < r) ? l : r;
                bx_hi = (l < r) ? r : l;
                by_lo = (t < b) ? t : b;
                by_hi = (t < b) ? b : t;
                cx_lo = (cur_left < cur_right) ? cur_left : cur_right;
                cx_hi = (cur_left < cur_right) ? cur_right : cur_left;
                cy_lo = (cur_top < cur_bottom) ? cur_top : cur_bottom;
                cy_hi = (cur_top < cur_bottom) ? cur_bottom : cur_top;
                cur_left   = (cx_lo < bx_lo) ? cx_lo : bx_lo;
                cur_right  = (cx_hi > bx_hi) ? cx_hi : bx_hi;
                cur_top    = (cy_lo < by_lo) ? cy_lo : by_lo;
                cur_bottom = (cy_hi > by_hi) ? cy_hi : by_hi;
            end
        end
        else
        begin
            // Close the old line, open a new one holding only this box
            if (line_open)
                close_line(idx, 1'b0, ovf);
            cur_left   = l;
            cur_top    = t;
            cur_right  = r;
            cur_bottom = b;
            cur_first  = idx;
            line_open  = 1'b1;
        end
        next_index = nxt;
        saturated  = ovf;
        // Flush the page on its final box
        if (last_flag)
        begin
            close_line(nxt, 1'b1, ovf);
            clear_page();
        end
    endfunction

    // Compare one result transaction with the oldest expected line
    function void match_line(text_line_t got);
        text_line_t  want;
        logic [15:0] want_f[8];
        logic [15:0] got_f[8];
        string       names[8];
        if (awaited_lines.size() == 0)
        begin
            $display("%0t: unexpected line, first_char %0d end_char %0d",
                     $time, got.first_char, got.end_char);
            mismatch_count++;
            return;
        end
        want  = awaited_lines.pop_front();
        names = '{"first_char", "end_char", "rect_left", "rect_top",
                  "rect_right", "rect_bottom", "last_line", "index_overflow"};
        want_f = '{want.first_char, want.end_char, want.rect_left, want.rect_top,
                   want.rect_right, want.rect_bottom, 16'(want.last_line),
                   16'(want.index_overflow)};
        got_f  = '{got.first_char, got.end_char, got.rect_left, got.rect_top,
                   got.rect_right, got.rect_bottom, 16'(got.last_line),
                   16'(got.index_overflow)};
        for (int i = 0; i < 8; i++)
        begin
            if (want_f[i] !== got_f[i])
            begin
                $display("%0t: %s expected %0d, got %0d",
                         $time, names[i], want_f[i], got_f[i]);
                mismatch_count++;
            end
        end
    endfunction

    function int pending();
        return awaited_lines.size();
    endfunction
endclass

module tb_top;
    localparam int COORD_BITS     = 16;
    localparam int INDEX_BITS     = 16;
    localparam int RANDOM_ITEMS   = 1250;
    localparam int HOLD_CYCLES    = 500;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    text_line_tracker lines = new();
    bit               src_gaps  = 1'b1;
    bit               sink_gaps = 1'b1;
    bit               hold_req  = 1'b0;
    int               quiet_cycles;

    text_line_grouping_unit #(
        .COORD_BITS (COORD_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one box, with random gaps ahead, and hold it until the transaction
    task automatic send_box(input logic [15:0] l, input logic [15:0] t,
                            input logic [15:0] r, input logic [15:0] b,
                            input bit last_flag);
        while (src_gaps && $urandom_range(0, 99) < 38)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, r, t, l};
        s_tlast  <= last_flag;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        lines.take_box(l, t, r, b, last_flag);
    endtask

    // Drive reset, directed pages, then random pages
    initial
    begin : stimulus
        int unsigned sent, n_boxes, row_y, pen_x, ht, wd, pick;
        bit          stretch_on, stretch_done;
        logic [15:0] l, t, r, b, tmp;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full-page box as a page of its own
        send_box(16'd0, 16'd0, 16'hffff, 16'hffff, 1'b1);
        // Joins, a null box, an inverted box, an exact touch, a null line replaced
        send_box(16'd10, 16'd100, 16'd20, 16'd120, 1'b0);
        send_box(16'd25, 16'd110, 16'd35, 16'd130, 1'b0);
        send_box(16'd50, 16'd115, 16'd50, 16'd115, 1'b0);
        send_box(16'd60, 16'd125, 16'd40, 16'd105, 1'b0);
        send_box(16'd70, 16'd130, 16'd80, 16'd140, 1'b0);
        send_box(16'd0, 16'd500, 16'd5, 16'd510, 1'b0);
        send_box(16'd200, 16'd600, 16'd200, 16'd600, 1'b0);
        send_box(16'd190, 16'd590, 16'd210, 16'd620, 1'b0);
        send_box(16'd0, 16'd1000, 16'd9, 16'd1010, 1'b1);
        // Null box at the bottom-right corner replaced by a full-page box
        send_box(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0);
        send_box(16'd0, 16'd0, 16'hffff, 16'hffff, 1'b1);
        // Inverted box opening a line, then misses on both sides
        send_box(16'd300, 16'd400, 16'd100, 16'd200, 1'b0);
        send_box(16'd0, 16'd0, 16'd1, 16'd1, 1'b0);
        send_box(16'd5, 16'd201, 16'd6, 16'd399, 1'b1);
        // Near misses just below and just above the open line
        send_box(16'd0, 16'd50, 16'd10, 16'd60, 1'b0);
        send_box(16'd20, 16'd61, 16'd30, 16'd70, 1'b0);
        send_box(16'd40, 16'd0, 16'd50, 16'd49, 1'b1);

        // Random pages of text rows, with noise boxes mixed in
        sent         = 0;
        stretch_on   = 1'b0;
        stretch_done = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            // Run a stretch with no gaps while the receiver holds off
            if (!stretch_done && sent >= 400)
            begin
                src_gaps     = 1'b0;
                sink_gaps    = 1'b0;
                hold_req     = 1'b1;
                stretch_on   = 1'b1;
                stretch_done = 1'b1;
            end
            else if (stretch_on && sent >= 750)
            begin
                src_gaps   = 1'b1;
                sink_gaps  = 1'b1;
                stretch_on = 1'b0;
            end
            n_boxes = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 25);
            row_y = $urandom_range(0, 60000);
            pen_x = $urandom_range(0, 4000);
            ht    = $urandom_range(1, 60);
            for (int unsigned i = 0; i < n_boxes; i++)
            begin
                pick = $urandom_range(0, 99);
                // Advance to a new row, wrapping back near the top of the page
                if (pick < 15 || pen_x > 64000)
                begin
                    row_y = row_y + ht + $urandom_range(1, 80);
                    if (row_y > 65000)
                        row_y = $urandom_range(0, 2000);
                    pen_x = $urandom_range(0, 4000);
                    ht    = $urandom_range(1, 60);
                end
                wd = $urandom_range(0, 40);
                l  = 16'(pen_x);
                r  = 16'(pen_x + wd);
                t  = 16'(row_y + $urandom_range(0, ht / 3));
                b  = 16'(row_y + ht - $urandom_range(0, ht / 3));
                pen_x = pen_x + wd + $urandom_range(0, 10);
                if (pick >= 85 && pick < 92)
                begin
                    l = 16'($urandom);
                    t = 16'($urandom);
                    r = 16'($urandom);
                    b = 16'($urandom);
                end
                else if (pick >= 92 && pick < 96)
                begin
                    r = l;
                    b = t;
                end
                else if (pick >= 96)
                begin
                    if ($urandom_range(0, 1))
                    begin
                        tmp = l;
                        l   = r;
                        r   = tmp;
                    end
                    else
                    begin
                        tmp = t;
                        t   = b;
                        b   = tmp;
                    end
                end
                send_box(l, t, r, b, i == n_boxes - 1);
            end
            sent = sent + n_boxes;
        end

        // Drain all owed lines, then let the block settle
        s_tvalid <= 1'b0;
        while (lines.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (lines.mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Accept and check lines; stall at random, and hold off once on request
    initial
    begin : line_sink
        text_line_t got;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.first_char     = m_tdata[15:0];
                got.end_char       = m_tdata[31:16];
                got.rect_left      = m_tdata[47:32];
                got.rect_top       = m_tdata[63:48];
                got.rect_right     = m_tdata[79:64];
                got.rect_bottom    = m_tdata[95:80];
                got.last_line      = m_tlast;
                got.index_overflow = m_tuser;
                lines.match_line(got);
            end
            if (hold_req && rst_n)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= rst_n && !(sink_gaps && $urandom_range(0, 99) < 38);
        end
    end

    // End the run when no transaction happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

/* text_line_grouping_unit.f */
design/tlg_pkg.sv
design/tlg_in_reg.sv
design/tlg_core.sv
design/tlg_out_fifo.sv
design/text_line_grouping_unit.sv
design/tlg_checker.sv
dv/tb_top.sv
